// ----- rtl/chbd_pkg.sv -----
// ----------------------------------------------------------------------------
// chbd_pkg
// Shared types, byte codes and helpers for the chunked body decoder.
// ----------------------------------------------------------------------------
package chbd_pkg;

  typedef enum logic [3:0] {
    PH_SIZE,
    PH_SIZE_LF,
    PH_EXT,
    PH_EXT_LF,
    PH_DATA,
    PH_DATA_CR,
    PH_DATA_LF,
    PH_LAST_CR,
    PH_LAST_LF,
    PH_DONE,
    PH_ERR
  } phase_t;

  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam logic [7:0] CHAR_CR   = 8'h0d;
  localparam logic [7:0] CHAR_LF   = 8'h0a;
  localparam logic [7:0] CHAR_SEMI = 8'h3b;

  localparam int CNT_WIDTH = 32;

  typedef struct packed {
    logic [7:0]           out_byte;
    logic                 out_valid;
    logic [1:0]           status;
    logic [CNT_WIDTH-1:0] body_length;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.value = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// ----- rtl/chbd_parser.sv -----
// ----------------------------------------------------------------------------
// chbd_parser
// Parser state and the per-byte step: size line, extension, payload, CR LF.
// ----------------------------------------------------------------------------
module chbd_parser #(
  parameter int SIZE_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        in_byte,
  input  logic              begin_req,
  output chbd_pkg::result_t result
);

  chbd_pkg::phase_t                  phase, phase_next, cur_phase;
  logic [SIZE_WIDTH-1:0]             chunk_rem, chunk_rem_next, cur_rem, rem_dec;
  logic                              digit_seen, digit_seen_next, cur_seen;
  logic [chbd_pkg::CNT_WIDTH-1:0]    decoded_count, decoded_count_next, cur_cnt;
  chbd_pkg::hex_t                    hex;
  logic                              pay;

  always_comb begin
    // A begin marker restarts the parse before this byte is looked at.
    cur_phase = begin_req ? chbd_pkg::PH_SIZE : phase;
    cur_rem   = begin_req ? '0 : chunk_rem;
    cur_seen  = begin_req ? 1'b0 : digit_seen;
    cur_cnt   = begin_req ? '0 : decoded_count;

    phase_next         = cur_phase;
    chunk_rem_next     = cur_rem;
    digit_seen_next    = cur_seen;
    decoded_count_next = cur_cnt;
    pay                = 1'b0;
    hex                = chbd_pkg::hex_decode(in_byte);
    rem_dec            = cur_rem - SIZE_WIDTH'(1);

    unique case (cur_phase)
      chbd_pkg::PH_SIZE: begin
        if (hex.ok) begin
          // Another digit would push bits out of the top of the size.
          if (cur_rem[SIZE_WIDTH-1 -: 4] != 4'd0) begin
            phase_next = chbd_pkg::PH_ERR;
          end else begin
            chunk_rem_next  = {cur_rem[SIZE_WIDTH-5:0], hex.value};
            digit_seen_next = 1'b1;
          end
        end else if (in_byte == chbd_pkg::CHAR_SEMI) begin
          phase_next = cur_seen ? chbd_pkg::PH_EXT : chbd_pkg::PH_ERR;
        end else if (in_byte == chbd_pkg::CHAR_CR) begin
          phase_next = cur_seen ? chbd_pkg::PH_SIZE_LF : chbd_pkg::PH_ERR;
        end else begin
          phase_next = chbd_pkg::PH_ERR;
        end
      end
      chbd_pkg::PH_SIZE_LF: begin
        if (in_byte == chbd_pkg::CHAR_LF) begin
          phase_next = (cur_rem == '0) ? chbd_pkg::PH_LAST_CR : chbd_pkg::PH_DATA;
        end else begin
          phase_next = chbd_pkg::PH_ERR;
        end
      end
      chbd_pkg::PH_EXT: begin
        if (in_byte == chbd_pkg::CHAR_CR) phase_next = chbd_pkg::PH_EXT_LF;
      end
      chbd_pkg::PH_EXT_LF: begin
        if (in_byte == chbd_pkg::CHAR_LF) begin
          phase_next = (cur_rem == '0) ? chbd_pkg::PH_LAST_CR : chbd_pkg::PH_DATA;
        end else if (in_byte != chbd_pkg::CHAR_CR) begin
          phase_next = chbd_pkg::PH_EXT;
        end
      end
      chbd_pkg::PH_DATA: begin
        pay            = 1'b1;
        chunk_rem_next = rem_dec;
        if (cur_cnt != '1) decoded_count_next = cur_cnt + chbd_pkg::CNT_WIDTH'(1);
        if (rem_dec == '0) phase_next = chbd_pkg::PH_DATA_CR;
      end
      chbd_pkg::PH_DATA_CR: begin
        phase_next = (in_byte == chbd_pkg::CHAR_CR) ? chbd_pkg::PH_DATA_LF
                                                    : chbd_pkg::PH_ERR;
      end
      chbd_pkg::PH_DATA_LF: begin
        if (in_byte == chbd_pkg::CHAR_LF) begin
          phase_next      = chbd_pkg::PH_SIZE;
          chunk_rem_next  = '0;
          digit_seen_next = 1'b0;
        end else begin
          phase_next = chbd_pkg::PH_ERR;
        end
      end
      chbd_pkg::PH_LAST_CR: begin
        phase_next = (in_byte == chbd_pkg::CHAR_CR) ? chbd_pkg::PH_LAST_LF
                                                    : chbd_pkg::PH_ERR;
      end
      chbd_pkg::PH_LAST_LF: begin
        phase_next = (in_byte == chbd_pkg::CHAR_LF) ? chbd_pkg::PH_DONE
                                                    : chbd_pkg::PH_ERR;
      end
      chbd_pkg::PH_DONE: begin
        phase_next = chbd_pkg::PH_DONE;
      end
      default: begin
        phase_next = chbd_pkg::PH_ERR;
      end
    endcase

    result.out_byte    = pay ? in_byte : 8'd0;
    result.out_valid   = pay;
    result.status      = (phase_next == chbd_pkg::PH_DONE) ? chbd_pkg::ST_DONE :
                         (phase_next == chbd_pkg::PH_ERR)  ? chbd_pkg::ST_ERR  :
                                                             chbd_pkg::ST_BUSY;
    result.body_length = decoded_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= chbd_pkg::PH_SIZE;
      chunk_rem     <= '0;
      digit_seen    <= 1'b0;
      decoded_count <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      chunk_rem     <= chunk_rem_next;
      digit_seen    <= digit_seen_next;
      decoded_count <= decoded_count_next;
    end
  end

  a_data_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == chbd_pkg::PH_DATA |-> chunk_rem != '0)
    else $error("payload phase with zero bytes remaining");

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    fire && !begin_req && phase == chbd_pkg::PH_DONE |=> phase == chbd_pkg::PH_DONE)
    else $error("complete status left without a begin marker");

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    fire && !begin_req && phase == chbd_pkg::PH_ERR |=> phase == chbd_pkg::PH_ERR)
    else $error("malformed status left without a begin marker");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(decoded_count) && $stable(phase))
    else $error("parser state changed without a byte");

endmodule

// ----- rtl/http_chunked_body_decoder.sv -----
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Decodes an HTTP/1.1 chunked body, one raw byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries in_byte and begin_req; set
//   begin_req on the first byte of each body to restart the parser.
//   Result channel (res_valid / res_stall) returns one item per input item:
//   out_byte and out_valid for payload bytes, status (in progress, complete,
//   malformed, sticky until the next begin) and the saturating body_length.
//   Each item passes through one input register, then the parser step lands in
//   the result register. Throughput is one item per clock while the receiver
//   does not stall, set by the single parser state update per byte.
//   When the receiver stalls, the result register holds and the input
//   register keeps one more item; in_stall rises once both are full.
//   Synchronous reset empties both registers and puts the parser at the
//   start of a size line with a zero length count.
//   SIZE_WIDTH sets the largest chunk size accepted, in bits.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder #(
  parameter int SIZE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        begin_req,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [7:0]  out_byte,
  output logic        out_valid,
  output logic [1:0]  status,
  output logic [31:0] body_length
);

  logic              in_reg_valid;
  logic [7:0]        in_reg_byte;
  logic              in_reg_begin;
  logic              res_free;
  logic              advance;
  chbd_pkg::result_t step_result;

  assign res_free = !res_valid || !res_stall;
  assign advance  = in_reg_valid && res_free;
  assign in_stall = in_reg_valid && !res_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_reg_byte  <= in_byte;
      in_reg_begin <= begin_req;
    end
  end

  chbd_parser #(
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .in_byte   (in_reg_byte),
    .begin_req (in_reg_begin),
    .result    (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= in_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte    <= step_result.out_byte;
      out_valid   <= step_result.out_valid;
      status      <= step_result.status;
      body_length <= step_result.body_length;
    end
  end

  a_payload_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && out_valid |-> status == chbd_pkg::ST_BUSY)
    else $error("payload byte reported with a final status");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_reg_valid && res_valid)
    else $error("input stalled while a register is empty");

endmodule
